FILE: src/trp_pkg.sv
// ----------------------------------------------------------------------------
// trp_pkg
// Types and constants shared by the touch report parser modules.
// ----------------------------------------------------------------------------
package trp_pkg;

  // Operating modes; the spare code behaves as the all-contacts mode
  typedef enum logic [1:0] {
    MODE_FIXED  = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_MULTI  = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MODE       = 2'd0,
    CFG_MAX_POINTS = 2'd1,
    CFG_MIN_COORD  = 2'd2,
    CFG_MAX_COORD  = 2'd3
  } cfg_index_t;

  localparam int CFG_DATA_W = 16;
  localparam int LEN_W      = 11;

  localparam logic [LEN_W-1:0] MIN_LEN_FIXED  = LEN_W'(59);
  localparam logic [LEN_W-1:0] MIN_LEN_RECORD = LEN_W'(44);
  localparam logic [7:0]       TOUCH_REPORT_ID = 8'h01;

  // Byte positions of the fixed layout
  localparam int FIXED_X_LO = 2;
  localparam int FIXED_X_HI = 3;
  localparam int FIXED_Y_LO = 6;
  localparam int FIXED_Y_HI = 7;

  // Record byte slots
  localparam logic [2:0] REC_HEAD = 3'd0;
  localparam logic [2:0] REC_X_LO = 3'd1;
  localparam logic [2:0] REC_X_HI = 3'd2;
  localparam logic [2:0] REC_Y_LO = 3'd3;
  localparam logic [2:0] REC_Y_HI = 3'd4;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic [7:0]       report_id;
    logic [LEN_W-1:0] report_length;
  } item_t;

  typedef struct packed {
    logic [15:0] touch_x;
    logic [15:0] touch_y;
    logic        touch_valid;
    logic [4:0]  contact_tag;
    logic        report_end;
    logic        report_rejected;
  } result_t;

  typedef struct packed {
    mode_t       mode;
    logic [4:0]  max_points;
    logic [15:0] min_coord;
    logic [15:0] max_coord;
  } cfg_t;

endpackage

FILE: src/touch_report_parser.sv
// ----------------------------------------------------------------------------
// touch_report_parser
// Byte-serial touch report parser with configuration registers.
// ----------------------------------------------------------------------------
// Output: each result is registered into the output register or the skid.
// Throughput: one report byte per cycle while item_stall is low; the two-entry
// result buffer keeps input flowing while one result waits downstream.
// Reset: synchronous; clears the walker state and the result buffer and loads
// the register defaults (all-contacts mode, five records, full range).
module touch_report_parser #(
  parameter int MAX_REPORT_BYTES = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  trp_pkg::cfg_index_t             cfg_index,
  input  logic [trp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  trp_pkg::item_t                  item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output trp_pkg::result_t                result
);

  trp_pkg::cfg_t    cfg;
  logic             accept;
  logic             push;
  trp_pkg::result_t push_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= trp_pkg::MODE_MULTI;
      cfg.max_points <= 5'd5;
      cfg.min_coord  <= 16'h0000;
      cfg.max_coord  <= 16'hFFFF;
    end else if (cfg_write) begin
      unique case (cfg_index)
        trp_pkg::CFG_MODE:       cfg.mode       <= trp_pkg::mode_t'(cfg_data[1:0]);
        trp_pkg::CFG_MAX_POINTS: cfg.max_points <= cfg_data[4:0];
        trp_pkg::CFG_MIN_COORD:  cfg.min_coord  <= cfg_data;
        trp_pkg::CFG_MAX_COORD:  cfg.max_coord  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = item_valid && !item_stall;

  trp_core #(
    .MAX_REPORT_BYTES(MAX_REPORT_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .item      (item),
    .push      (push),
    .push_data (push_data)
  );

  trp_skid u_skid (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_data    (push_data),
    .full         (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Input stalls only while a result is already waiting at the output
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("input stalled with no pending result");

  // Reset empties the result buffer
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("result buffer not empty after reset");

  // A rejected report always closes the report
  a_reject_is_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.report_rejected |-> result.report_end)
    else $error("rejected result without end flag");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

endmodule

FILE: src/trp_core.sv
// ----------------------------------------------------------------------------
// trp_core
// Per-byte report walker: tracks position and record state, forms results.
// ----------------------------------------------------------------------------
module trp_core #(
  parameter int MAX_REPORT_BYTES = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  trp_pkg::cfg_t    cfg,
  input  logic             accept,
  input  trp_pkg::item_t   item,
  output logic             push,
  output trp_pkg::result_t push_data
);

  localparam int BPW = $clog2(MAX_REPORT_BYTES);
  localparam int LW  = (BPW + 1 > trp_pkg::LEN_W) ? BPW + 1 : trp_pkg::LEN_W;

  logic [BPW-1:0] byte_position;
  logic [2:0]     record_byte;
  logic [4:0]     record_count;
  logic           record_tip;
  logic [4:0]     record_tag;
  logic [15:0]    record_x;
  logic [7:0]     record_y_low;
  logic [15:0]    held_x;
  logic [15:0]    held_y;
  logic [4:0]     held_tag;
  logic           held_found;

  logic [LW-1:0]  len_ext;
  logic [LW-1:0]  len_sat;
  logic [LW-1:0]  pos_inc;
  logic [trp_pkg::LEN_W-1:0] min_len;
  logic           rej;
  logic           last;
  logic           rec_active;
  logic [15:0]    rec_y;
  logic           rec_ok;

  function automatic logic in_range(input logic [15:0] x, input logic [15:0] y,
                                    input logic [15:0] lo, input logic [15:0] hi);
    return (x >= lo) && (x <= hi) && (y >= lo) && (y <= hi);
  endfunction

  // Clamp the length and classify the byte
  always_comb begin
    len_ext = LW'(item.report_length);
    if (len_ext == '0) begin
      len_sat = LW'(1);
    end else if (len_ext > LW'(MAX_REPORT_BYTES)) begin
      len_sat = LW'(MAX_REPORT_BYTES);
    end else begin
      len_sat = len_ext;
    end
    pos_inc    = LW'(byte_position) + LW'(1);
    last       = pos_inc >= len_sat;
    min_len    = (cfg.mode == trp_pkg::MODE_FIXED) ? trp_pkg::MIN_LEN_FIXED
                                                   : trp_pkg::MIN_LEN_RECORD;
    rej        = (item.report_id != trp_pkg::TOUCH_REPORT_ID) ||
                 (LW'(item.report_length) < LW'(min_len)) || (len_ext == '0);
    rec_active = (byte_position != '0) && (record_count < cfg.max_points);
    rec_y      = {item.data_byte, record_y_low};
    rec_ok     = record_tip && in_range(record_x, rec_y, cfg.min_coord, cfg.max_coord);
  end

  // Form the result for this byte
  always_comb begin
    push      = 1'b0;
    push_data = '0;
    if (last) begin
      push                = accept;
      push_data.report_end = 1'b1;
      if (rej) begin
        push_data.report_rejected = 1'b1;
      end else if (cfg.mode == trp_pkg::MODE_FIXED) begin
        push_data.touch_x     = record_x;
        push_data.touch_y     = held_y;
        push_data.touch_valid = in_range(record_x, held_y, cfg.min_coord, cfg.max_coord);
      end else if (cfg.mode == trp_pkg::MODE_SINGLE && held_found) begin
        push_data.touch_x     = held_x;
        push_data.touch_y     = held_y;
        push_data.touch_valid = 1'b1;
        push_data.contact_tag = held_tag;
      end
    end else if (!rej && cfg.mode != trp_pkg::MODE_FIXED &&
                 cfg.mode != trp_pkg::MODE_SINGLE && rec_active &&
                 record_byte == trp_pkg::REC_Y_HI && rec_ok) begin
      push                  = accept;
      push_data.touch_x     = record_x;
      push_data.touch_y     = rec_y;
      push_data.touch_valid = 1'b1;
      push_data.contact_tag = record_tag;
    end
  end

  // Advance the walker state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      byte_position <= '0;
      record_byte   <= '0;
      record_count  <= '0;
      record_tip    <= 1'b0;
      record_tag    <= '0;
      record_x      <= '0;
      record_y_low  <= '0;
      held_x        <= '0;
      held_y        <= '0;
      held_tag      <= '0;
      held_found    <= 1'b0;
    end else if (accept) begin
      byte_position <= byte_position + BPW'(1);
      if (!rej) begin
        if (cfg.mode == trp_pkg::MODE_FIXED) begin
          if (byte_position == BPW'(trp_pkg::FIXED_X_LO)) begin
            record_x <= {8'h00, item.data_byte};
          end else if (byte_position == BPW'(trp_pkg::FIXED_X_HI)) begin
            record_x <= {item.data_byte, record_x[7:0]};
          end else if (byte_position == BPW'(trp_pkg::FIXED_Y_LO)) begin
            record_y_low <= item.data_byte;
          end else if (byte_position == BPW'(trp_pkg::FIXED_Y_HI)) begin
            held_y <= {item.data_byte, record_y_low};
          end
        end else if (rec_active) begin
          unique case (record_byte)
            trp_pkg::REC_HEAD: begin
              record_tip <= item.data_byte[0];
              record_tag <= item.data_byte[7:3];
            end
            trp_pkg::REC_X_LO: record_x     <= {8'h00, item.data_byte};
            trp_pkg::REC_X_HI: record_x     <= {item.data_byte, record_x[7:0]};
            trp_pkg::REC_Y_LO: record_y_low <= item.data_byte;
            default: begin
              // Hold the first good contact in single mode
              if (rec_ok && cfg.mode == trp_pkg::MODE_SINGLE && !held_found) begin
                held_x     <= record_x;
                held_y     <= rec_y;
                held_tag   <= record_tag;
                held_found <= 1'b1;
              end
              record_count <= record_count + 5'd1;
            end
          endcase
          record_byte <= (record_byte >= trp_pkg::REC_Y_HI) ? trp_pkg::REC_HEAD
                                                            : record_byte + 3'd1;
        end
      end
    end
  end

endmodule

FILE: src/trp_skid.sv
// ----------------------------------------------------------------------------
// trp_skid
// Two-entry result buffer: output register plus one skid register.
// ----------------------------------------------------------------------------
module trp_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  trp_pkg::result_t push_data,
  output logic             full,
  output logic             result_valid,
  input  logic             result_stall,
  output trp_pkg::result_t result
);

  logic             skid_valid;
  trp_pkg::result_t skid_data;
  logic             pop;

  assign pop  = result_valid && !result_stall;
  assign full = skid_valid;

  // Refill from the skid first; new requests arrive only when it is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        result       <= skid_data;
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end
    end else if (push) begin
      if (!result_valid || pop) begin
        result       <= push_data;
        result_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      result_valid <= 1'b0;
    end
  end

endmodule
